>>> hw/rtl/delayed_wave_force_law_macros.svh
// assertion macros for the delayed wave force law block
// clocked on i_clk and disabled while i_rst_n is low in the including module
`ifndef DELAYED_WAVE_FORCE_LAW_MACROS_SVH
`define DELAYED_WAVE_FORCE_LAW_MACROS_SVH

// same-cycle implication
`define DWF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dwf_pkg.sv
// shared types, constants and fixed point helpers for the delayed wave force law block
// no dependencies
`default_nettype none

package dwf_pkg;

    typedef logic signed [15:0] t_s16;
    typedef logic [47:0]        t_force3;

    typedef enum logic [1:0] {
        CFG_SPRING_GAIN  = 2'd0,
        CFG_WAVE_GAIN    = 2'd1,
        CFG_DAMPING_GAIN = 2'd2,
        CFG_DELAY_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_lane_ctl;

    localparam t_s16       SPRING_GAIN_RST  = 16'sd164;
    localparam t_s16       WAVE_GAIN_RST    = 16'sd4096;
    localparam t_s16       DAMPING_GAIN_RST = 16'sd0;
    localparam logic [8:0] DELAY_LENGTH_RST = 9'd1;

    // q4.12 product to integer, round half up
    function automatic logic signed [21:0] q12_round(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = p + 34'sd2048;
        return t[33:12];
    endfunction

    function automatic t_s16 sat16(input logic signed [23:0] v);
        t_s16 res;
        if (v > 24'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dwf_in_if.sv
// input channel: positions and velocity on three axes
// depends on dwf_pkg
`default_nettype none

interface dwf_in_if;
    import dwf_pkg::*;

    logic valid;
    logic ready;
    t_s16 local_pos_x;
    t_s16 local_pos_y;
    t_s16 local_pos_z;
    t_s16 remote_pos_x;
    t_s16 remote_pos_y;
    t_s16 remote_pos_z;
    t_s16 local_vel_x;
    t_s16 local_vel_y;
    t_s16 local_vel_z;

    modport source (
        output valid, local_pos_x, local_pos_y, local_pos_z,
        output remote_pos_x, remote_pos_y, remote_pos_z,
        output local_vel_x, local_vel_y, local_vel_z,
        input  ready
    );

    modport sink (
        input  valid, local_pos_x, local_pos_y, local_pos_z,
        input  remote_pos_x, remote_pos_y, remote_pos_z,
        input  local_vel_x, local_vel_y, local_vel_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/dwf_out_if.sv
// output channel: applied and spring forces on three axes
// depends on dwf_pkg
`default_nettype none

interface dwf_out_if;
    import dwf_pkg::*;

    logic valid;
    logic ready;
    t_s16 applied_force_x;
    t_s16 applied_force_y;
    t_s16 applied_force_z;
    t_s16 spring_force_x;
    t_s16 spring_force_y;
    t_s16 spring_force_z;

    modport source (
        output valid, applied_force_x, applied_force_y, applied_force_z,
        output spring_force_x, spring_force_y, spring_force_z,
        input  ready
    );

    modport sink (
        input  valid, applied_force_x, applied_force_y, applied_force_z,
        input  spring_force_x, spring_force_y, spring_force_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/dwf_cfg_if.sv
// configuration write channel: register index and write data
// depends on dwf_pkg
`default_nettype none

interface dwf_cfg_if;
    import dwf_pkg::*;

    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/dwf_lane.sv
// one axis of the force law: spring and damping products, rounding, wave cancel
// depends on dwf_pkg; the delayed force comes from dwf_ring
`default_nettype none

module dwf_lane (
    input  wire logic              i_clk,
    input  wire dwf_pkg::t_lane_ctl i_ctl,
    input  wire dwf_pkg::t_s16     i_local_pos,
    input  wire dwf_pkg::t_s16     i_remote_pos,
    input  wire dwf_pkg::t_s16     i_local_vel,
    input  wire dwf_pkg::t_s16     i_spring_gain,
    input  wire dwf_pkg::t_s16     i_wave_gain,
    input  wire dwf_pkg::t_s16     i_damping_gain,
    input  wire dwf_pkg::t_s16     i_delayed,
    output dwf_pkg::t_s16          o_spring_new,
    output dwf_pkg::t_s16          o_spring,
    output dwf_pkg::t_s16          o_applied
);
    import dwf_pkg::*;

    logic signed [33:0] n_p_spring, r_p_spring;
    logic signed [31:0] n_p_damp, r_p_damp;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_neg_gain;
    t_s16               r_spring2, r_spring3;
    logic signed [21:0] r_damp2, r_damp3;
    logic signed [31:0] n_p_wave, r_p_wave;
    logic signed [23:0] w_sum;

    always_comb begin
        w_diff     = 17'(i_local_pos) - 17'(i_remote_pos);
        w_neg_gain = -17'(i_spring_gain);
        n_p_spring = 34'(w_neg_gain) * 34'(w_diff);
        n_p_damp   = 32'(i_damping_gain) * 32'(i_local_vel);
    end

    assign o_spring_new = sat16(24'(q12_round(r_p_spring)));

    assign n_p_wave = 32'(i_wave_gain) * 32'(i_delayed);

    always_comb begin
        w_sum = 24'(r_spring3) - 24'(q12_round(34'(r_p_wave))) - 24'(r_damp3);
    end

    assign o_applied = sat16(w_sum);
    assign o_spring  = r_spring3;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_p_spring <= n_p_spring;
            r_p_damp   <= n_p_damp;
        end
        if (i_ctl.ld2) begin
            r_spring2 <= o_spring_new;
            r_damp2   <= q12_round(34'(r_p_damp));
        end
        if (i_ctl.ld3) begin
            r_p_wave  <= n_p_wave;
            r_spring3 <= r_spring2;
            r_damp3   <= r_damp2;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dwf_ring.sv
// force delay ring: one 48-bit entry per item, registered read of the delayed entry
// depends on dwf_pkg; a fill count stands in for clearing the ring at reset
`default_nettype none

module dwf_ring #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_ld,
    input  wire dwf_pkg::t_force3 i_wdata,
    input  wire logic [8:0]       i_delay_length,
    output dwf_pkg::t_force3      o_delayed
);
    import dwf_pkg::*;

    localparam int IDXW  = $clog2(RING_DEPTH);
    localparam int FILLW = $clog2(RING_DEPTH + 1);
    localparam int CMPW  = (IDXW + 1 > 9) ? IDXW + 1 : 9;

    t_force3 mem [RING_DEPTH];

    logic [IDXW-1:0]  r_idx, n_idx;
    logic [FILLW-1:0] r_fill, n_fill;
    logic [IDXW:0]    w_idx_inc;
    logic             w_wrap;
    logic             w_rd_ok;
    logic             w_bypass;
    t_force3          r_rdata;
    t_force3          r_wdata;
    logic             r_rd_ok;
    logic             r_bypass;

    always_comb begin
        w_idx_inc = {1'b0, r_idx} + (IDXW + 1)'(1);
        // zero length behaves as one, lengths past the depth as the depth
        w_wrap    = (CMPW'(w_idx_inc) >= CMPW'(i_delay_length))
                    || (r_idx == IDXW'(RING_DEPTH - 1));
        n_idx     = w_wrap ? '0 : w_idx_inc[IDXW-1:0];
        n_fill    = (FILLW'(r_idx) == r_fill) ? FILLW'(r_fill + FILLW'(1)) : r_fill;
        w_rd_ok   = FILLW'(n_idx) < n_fill;
        w_bypass  = n_idx == r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_fill <= '0;
        end else if (i_ld) begin
            r_idx  <= n_idx;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            mem[r_idx] <= i_wdata;
            r_rdata    <= mem[n_idx];
            r_wdata    <= i_wdata;
            r_rd_ok    <= w_rd_ok;
            r_bypass   <= w_bypass;
        end
    end

    assign o_delayed = r_bypass ? r_wdata : (r_rd_ok ? r_rdata : '0);

endmodule

`default_nettype wire

>>> hw/rtl/delayed_wave_force_law.sv
// top level: three axis lanes, shared force delay ring, output merge register
// depends on dwf_pkg, dwf_in_if, dwf_out_if, dwf_cfg_if, dwf_lane, dwf_ring
//
// channel   direction  transfer when        payload
// i_in      in         valid && ready       local/remote position, local velocity, x y z
// o_out     out        valid && ready       applied force, spring force, x y z
// i_cfg     in         valid (ready is 1)   register index, 16-bit data
//
// one item per cycle sustained while o_out.ready stays high; output valid once the item has passed the stages below
// stages: gain products, round and ring access, wave product, saturate into output register
// the ring read port is registered, so ring access takes its own stage
// reset: ring entries read as zero until written (fill count), no clearing pass
// stalls: each stage holds while the one after it is full and held; ready drops only when all are full
`default_nettype none

`include "delayed_wave_force_law_macros.svh"

module delayed_wave_force_law #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dwf_in_if.sink    i_in,
    dwf_out_if.source o_out,
    dwf_cfg_if.sink   i_cfg
);
    import dwf_pkg::*;

    t_s16       r_spring_gain;
    t_s16       r_wave_gain;
    t_s16       r_damping_gain;
    logic [8:0] r_delay_length;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_free1, w_free2, w_free3, w_free4;
    t_lane_ctl w_ctl;
    logic w_ld4;

    t_s16    w_loc [3];
    t_s16    w_rem [3];
    t_s16    w_vel [3];
    t_s16    w_spring_new [3];
    t_s16    w_spring [3];
    t_s16    w_applied [3];
    t_force3 w_wdata;
    t_force3 w_delayed;

    t_s16 r_applied [3];
    t_s16 r_spring_out [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_gain  <= SPRING_GAIN_RST;
            r_wave_gain    <= WAVE_GAIN_RST;
            r_damping_gain <= DAMPING_GAIN_RST;
            r_delay_length <= DELAY_LENGTH_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_SPRING_GAIN:  r_spring_gain  <= i_cfg.data;
                CFG_WAVE_GAIN:    r_wave_gain    <= i_cfg.data;
                CFG_DAMPING_GAIN: r_damping_gain <= i_cfg.data;
                CFG_DELAY_LENGTH: r_delay_length <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_free4   = !r_v4 || o_out.ready;
        w_free3   = !r_v3 || w_free4;
        w_free2   = !r_v2 || w_free3;
        w_free1   = !r_v1 || w_free2;
        w_ctl.ld1 = i_in.valid && w_free1;
        w_ctl.ld2 = r_v1 && w_free2;
        w_ctl.ld3 = r_v2 && w_free3;
        w_ld4     = r_v3 && w_free4;
    end

    assign i_in.ready = w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_free1) begin
                r_v1 <= i_in.valid;
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free3) begin
                r_v3 <= r_v2;
            end
            if (w_free4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign w_loc[0] = i_in.local_pos_x;
    assign w_loc[1] = i_in.local_pos_y;
    assign w_loc[2] = i_in.local_pos_z;
    assign w_rem[0] = i_in.remote_pos_x;
    assign w_rem[1] = i_in.remote_pos_y;
    assign w_rem[2] = i_in.remote_pos_z;
    assign w_vel[0] = i_in.local_vel_x;
    assign w_vel[1] = i_in.local_vel_y;
    assign w_vel[2] = i_in.local_vel_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        dwf_lane u_lane (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_local_pos    (w_loc[g]),
            .i_remote_pos   (w_rem[g]),
            .i_local_vel    (w_vel[g]),
            .i_spring_gain  (r_spring_gain),
            .i_wave_gain    (r_wave_gain),
            .i_damping_gain (r_damping_gain),
            .i_delayed      (w_delayed[16*g +: 16]),
            .o_spring_new   (w_spring_new[g]),
            .o_spring       (w_spring[g]),
            .o_applied      (w_applied[g])
        );
        assign w_wdata[16*g +: 16] = w_spring_new[g];
    end

    dwf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ld           (w_ctl.ld2),
        .i_wdata        (w_wdata),
        .i_delay_length (r_delay_length),
        .o_delayed      (w_delayed)
    );

    // merge the three lanes into one result
    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            for (int a = 0; a < 3; a++) begin
                r_applied[a]    <= w_applied[a];
                r_spring_out[a] <= w_spring[a];
            end
        end
    end

    assign o_out.valid           = r_v4;
    assign o_out.applied_force_x = r_applied[0];
    assign o_out.applied_force_y = r_applied[1];
    assign o_out.applied_force_z = r_applied[2];
    assign o_out.spring_force_x  = r_spring_out[0];
    assign o_out.spring_force_y  = r_spring_out[1];
    assign o_out.spring_force_z  = r_spring_out[2];

    `DWF_ASSERT_NOW(a_ready_only_when_full, !i_in.ready, r_v1 && r_v2 && r_v3 && r_v4, "input stalled with a free stage")
    `DWF_ASSERT_NEXT(a_stage3_holds, r_v3 && !w_free4, r_v3, "stage 3 item lost during stall")
    `DWF_ASSERT_NOW(a_out_from_stage3, $rose(o_out.valid), $past(r_v3), "output valid without an item in stage 3")

endmodule

`default_nettype wire
